FILE: design/dbplh_pkg.sv
// Shared constants, command struct and cosine table for the DFT band-power LED block.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps

package dbplh_pkg;

   localparam int FRAME_SIZE    = 32;
   localparam int IDX_W         = $clog2(FRAME_SIZE);
   localparam int CNT_W         = IDX_W + 1;
   localparam int LED_COUNT     = 8;
   localparam int LED_W         = 3;
   localparam int TWIDDLE_SHIFT = 6;
   localparam int SMP_W         = 8;
   localparam int TW_W          = 8;
   localparam int ACC_W         = 16;
   localparam int SQ_W          = 2 * ACC_W;
   localparam int POW_SHIFT     = 2 * IDX_W;
   localparam int POW_W         = 16;
   localparam int HOLD_W        = 8;
   localparam int CSR_ADDR_W    = 1;
   localparam int CSR_DATA_W    = 16;
   localparam int RSP_DATA_W    = 32;

   // sine term is read a three-quarter turn ahead of the cosine term
   localparam logic [IDX_W-1:0] SIN_OFFSET = IDX_W'(3 * FRAME_SIZE / 4);
   // the last LED ends up with the top bin
   localparam logic [IDX_W-1:0] TOP_BIN    = IDX_W'(FRAME_SIZE / 2);

   localparam logic [CSR_ADDR_W-1:0] REG_POWER_THRESHOLD = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_HOLD_MAX        = 1'd1;

   localparam logic [HOLD_W-1:0] HOLD_MAX_RESET = 8'd16;

   typedef struct packed {
      logic             smp_we;   // store one sample at addr
      logic [IDX_W-1:0] addr;     // sample store address
      logic             issue;    // read one sample and twiddle pair
      logic             acc_clr;  // first term of a bin
      logic             square;   // square both accumulators
      logic             update;   // finish bin: power, hold, output register
      logic [LED_W-1:0] bin;      // LED being computed
   } cmd_type;

   // 64 * cos(2*pi*m/32), truncated toward zero
   function automatic logic signed [TW_W-1:0] twiddle(input logic [IDX_W-1:0] m);
      logic signed [TW_W-1:0] v;
      case (m)
         5'd0:  v = 8'sd64;
         5'd1:  v = 8'sd62;
         5'd2:  v = 8'sd59;
         5'd3:  v = 8'sd53;
         5'd4:  v = 8'sd45;
         5'd5:  v = 8'sd35;
         5'd6:  v = 8'sd24;
         5'd7:  v = 8'sd12;
         5'd8:  v = 8'sd0;
         5'd9:  v = -8'sd12;
         5'd10: v = -8'sd24;
         5'd11: v = -8'sd35;
         5'd12: v = -8'sd45;
         5'd13: v = -8'sd53;
         5'd14: v = -8'sd59;
         5'd15: v = -8'sd62;
         5'd16: v = -8'sd64;
         5'd17: v = -8'sd62;
         5'd18: v = -8'sd59;
         5'd19: v = -8'sd53;
         5'd20: v = -8'sd45;
         5'd21: v = -8'sd35;
         5'd22: v = -8'sd24;
         5'd23: v = -8'sd12;
         5'd24: v = 8'sd0;
         5'd25: v = 8'sd12;
         5'd26: v = 8'sd24;
         5'd27: v = 8'sd35;
         5'd28: v = 8'sd45;
         5'd29: v = 8'sd53;
         5'd30: v = 8'sd59;
         5'd31: v = 8'sd62;
         default: v = 8'sd0;
      endcase
      return v;
   endfunction

endpackage

FILE: design/dbplh_ctrl.sv
// Sequencer for the DFT band-power LED block: sample collection, per-bin
// multiply-accumulate sweep, power and hold update, result hand-off. Uses dbplh_pkg.
`timescale 1ns / 1ps

module dbplh_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output dbplh_pkg::cmd_type cmd
);
   import dbplh_pkg::*;

   localparam logic [2:0] ST_COLLECT = 3'd0;
   localparam logic [2:0] ST_MAC     = 3'd1;
   localparam logic [2:0] ST_SQUARE  = 3'd2;
   localparam logic [2:0] ST_POWER   = 3'd3;
   localparam logic [2:0] ST_EMIT    = 3'd4;

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [LED_W-1:0] bin_ff, bin_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_COLLECT;
         cnt_ff   <= '0;
         bin_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         bin_ff   <= bin_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      bin_in      = bin_ff;
      req_tready  = 1'b0;
      rsp_tvalid  = 1'b0;
      cmd         = '0;
      cmd.addr    = cnt_ff[IDX_W-1:0];
      cmd.bin     = bin_ff;
      case (state_ff)
         ST_COLLECT: begin
            req_tready = 1'b1;
            cmd.smp_we = req_tvalid;
            if (req_tvalid) begin
               if (cnt_ff == CNT_W'(FRAME_SIZE - 1)) begin
                  cnt_in   = '0;
                  bin_in   = '0;
                  state_in = ST_MAC;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         ST_MAC: begin
            // one extra count drains the read and accumulate stage
            cmd.issue   = (cnt_ff != CNT_W'(FRAME_SIZE));
            cmd.acc_clr = (cnt_ff == '0);
            if (cnt_ff == CNT_W'(FRAME_SIZE)) begin
               state_in = ST_SQUARE;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_SQUARE: begin
            cmd.square = 1'b1;
            state_in   = ST_POWER;
         end
         ST_POWER: begin
            cmd.update = 1'b1;
            state_in   = ST_EMIT;
         end
         ST_EMIT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               cnt_in = '0;
               if (bin_ff == LED_W'(LED_COUNT - 1)) begin
                  state_in = ST_COLLECT;
               end else begin
                  bin_in   = bin_ff + 1'b1;
                  state_in = ST_MAC;
               end
            end
         end
         default: begin
            state_in = ST_COLLECT;
            cnt_in   = '0;
         end
      endcase
   end

endmodule

FILE: design/dbplh_datapath.sv
// Datapath of the DFT band-power LED block: sample store, twiddle lookup,
// re/im multiply-accumulate, power, hold counters and result register. Uses dbplh_pkg.
`timescale 1ns / 1ps

module dbplh_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  dbplh_pkg::cmd_type                cmd,
   input  logic [dbplh_pkg::SMP_W-1:0]       req_sample,
   input  logic                              csr_we,
   input  logic [dbplh_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [dbplh_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output logic [dbplh_pkg::LED_W-1:0]       rsp_led_index,
   output logic [dbplh_pkg::POW_W-1:0]       rsp_band_power,
   output logic                              rsp_led_on,
   output logic [dbplh_pkg::HOLD_W-1:0]      rsp_hold_level,
   output logic                              rsp_last
);
   import dbplh_pkg::*;

   logic [SMP_W-1:0] smp_mem [FRAME_SIZE];

   logic [POW_W-1:0]  thr_ff;
   logic [HOLD_W-1:0] hold_max_ff;

   logic [IDX_W-1:0]        k_sel;
   logic [IDX_W-1:0]        phase_ff;
   logic [IDX_W-1:0]        cos_idx;
   logic signed [SMP_W-1:0] smp_ff;
   logic signed [TW_W-1:0]  tw_cos_ff, tw_sin_ff;
   logic                    issue_d_ff;

   logic signed [2*SMP_W-1:0] prod_re, prod_im;
   logic signed [ACC_W-1:0]   acc_re_ff, acc_im_ff;
   logic [SQ_W-1:0]           sq_re_ff, sq_im_ff;
   logic [SQ_W:0]             sq_sum, sq_scaled;
   logic [POW_W-1:0]          power;

   logic [HOLD_W-1:0] hold_ff [LED_COUNT];
   logic              lit_ff  [LED_COUNT];
   logic [HOLD_W-1:0] hold_cur, hold_in;
   logic              lit_in;

   logic [LED_W-1:0]  out_idx_ff;
   logic [POW_W-1:0]  out_pow_ff;
   logic              out_on_ff;
   logic [HOLD_W-1:0] out_hold_ff;
   logic              out_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff      <= '0;
         hold_max_ff <= HOLD_MAX_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            REG_POWER_THRESHOLD: thr_ff      <= csr_wdata;
            REG_HOLD_MAX:        hold_max_ff <= csr_wdata[HOLD_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.smp_we) begin
         smp_mem[cmd.addr] <= req_sample;
      end
      if (cmd.issue) begin
         smp_ff <= $signed(smp_mem[cmd.addr]);
      end
   end

   // LEDs below the last one take bins 1..7, the last one takes the top bin
   assign k_sel   = (cmd.bin == LED_W'(LED_COUNT - 1)) ? TOP_BIN : IDX_W'(cmd.bin) + 1'b1;
   assign cos_idx = cmd.acc_clr ? '0 : phase_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         issue_d_ff <= 1'b0;
      end else begin
         issue_d_ff <= cmd.issue;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         phase_ff  <= cos_idx + k_sel;
         tw_cos_ff <= twiddle(cos_idx);
         tw_sin_ff <= twiddle(cos_idx + SIN_OFFSET);
      end
   end

   assign prod_re = smp_ff * tw_cos_ff;
   assign prod_im = smp_ff * tw_sin_ff;

   always_ff @(posedge clock) begin
      if (cmd.acc_clr) begin
         acc_re_ff <= '0;
         acc_im_ff <= '0;
      end else if (issue_d_ff) begin
         acc_re_ff <= acc_re_ff + ACC_W'(prod_re >>> TWIDDLE_SHIFT);
         acc_im_ff <= acc_im_ff - ACC_W'(prod_im >>> TWIDDLE_SHIFT);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.square) begin
         sq_re_ff <= $unsigned(SQ_W'(acc_re_ff) * SQ_W'(acc_re_ff));
         sq_im_ff <= $unsigned(SQ_W'(acc_im_ff) * SQ_W'(acc_im_ff));
      end
   end

   assign sq_sum    = {1'b0, sq_re_ff} + {1'b0, sq_im_ff};
   assign sq_scaled = sq_sum >> POW_SHIFT;
   assign power     = (|sq_scaled[SQ_W:POW_W]) ? '1 : sq_scaled[POW_W-1:0];

   assign hold_cur = hold_ff[cmd.bin];

   always_comb begin
      hold_in = hold_cur;
      lit_in  = lit_ff[cmd.bin];
      if (power > thr_ff) begin
         if (hold_cur < hold_max_ff) begin
            hold_in = hold_cur + 1'b1;
         end
         lit_in = 1'b1;
      end else if (hold_cur != '0) begin
         hold_in = hold_cur - 1'b1;
      end else begin
         lit_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LED_COUNT; i++) begin
            hold_ff[i] <= '0;
            lit_ff[i]  <= 1'b0;
         end
      end else if (cmd.update) begin
         hold_ff[cmd.bin] <= hold_in;
         lit_ff[cmd.bin]  <= lit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         out_idx_ff  <= cmd.bin;
         out_pow_ff  <= power;
         out_on_ff   <= lit_in;
         out_hold_ff <= hold_in;
         out_last_ff <= (cmd.bin == LED_W'(LED_COUNT - 1));
      end
   end

   assign rsp_led_index  = out_idx_ff;
   assign rsp_band_power = out_pow_ff;
   assign rsp_led_on     = out_on_ff;
   assign rsp_hold_level = out_hold_ff;
   assign rsp_last       = out_last_ff;

endmodule

FILE: design/dft_band_power_led_hold.sv
// Top level of the DFT band-power LED block: joins the sequencer and the datapath.
// Depends on dbplh_pkg, dbplh_ctrl and dbplh_datapath.
`timescale 1ns / 1ps

// Takes 32 signed 8-bit samples, one per cycle while req_tready is high. After the
// 32nd it computes the 32-point DFT power of bins 1..7 and 16, one bin at a time on
// a single multiply-accumulate pair fed by a one-port sample store: a sweep over the
// frame per bin, then a square step and an update of the LED hold counter, then the
// result waits in the output register until taken. req_tready stays low from the
// 32nd sample until the eighth result (tlast) is taken. Power is (re^2 + im^2) /
// 1024, saturated to 16 bits. Register 0 is the power threshold, register 1 the
// hold limit (reset 16); write them only while no frame is pending.
module dft_band_power_led_hold (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,  // [7:0] sample
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [2:0] led_index, [18:3] band_power, [19] led_on, [27:20] hold_level, [31:28] zero
   output logic [dbplh_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                              rsp_tlast,
   input  logic                              csr_we,
   input  logic [dbplh_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [dbplh_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import dbplh_pkg::*;

   cmd_type           cmd;
   logic [LED_W-1:0]  led_index;
   logic [POW_W-1:0]  band_power;
   logic              led_on;
   logic [HOLD_W-1:0] hold_level;

   dbplh_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   dbplh_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_sample     (req_tdata),
      .csr_we         (csr_we),
      .csr_addr       (csr_addr),
      .csr_wdata      (csr_wdata),
      .rsp_led_index  (led_index),
      .rsp_band_power (band_power),
      .rsp_led_on     (led_on),
      .rsp_hold_level (hold_level),
      .rsp_last       (rsp_tlast)
   );

   assign rsp_tdata = {4'b0000, hold_level, led_on, band_power, led_index};

endmodule

FILE: design/dbplh_checker.sv
// Port-level checks for the DFT band-power LED block, bound to its top level.
// Depends on dbplh_pkg and dft_band_power_led_hold.
`timescale 1ns / 1ps

module dbplh_port_checks (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [dbplh_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input logic                              rsp_tlast
);
   import dbplh_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // no request is taken while a frame's results are pending
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("request accepted during result delivery");

   // tlast marks exactly the last LED
   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tdata[2:0] == LED_W'(LED_COUNT - 1))))
      else $error("tlast does not match LED index");

   // a dark LED always has an empty hold counter
   a_dark_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[19] |-> rsp_tdata[27:20] == '0)
      else $error("dark LED with nonzero hold");

   // after a non-final result the block keeps computing, not collecting
   a_frame_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> !req_tready)
      else $error("request taken before frame results done");

endmodule

bind dft_band_power_led_hold dbplh_port_checks u_dbplh_checker (.*);
